>>> src/ljf_pkg.sv
// ----------------------------------------------------------------------------
// ljf_pkg
// Shared types and constants for the longest-job-first scheduler.
// ----------------------------------------------------------------------------
package ljf_pkg;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int TIME_W = 24;
	localparam int IDX_W  = 4;

	typedef struct packed {
		logic [ARR_W-1:0] arrival_time;
		logic [BUR_W-1:0] burst_length;
		logic             last_job;
	} job_t;

	typedef struct packed {
		logic [IDX_W-1:0]  job_index;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] waiting_time;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic [ARR_W-1:0] arrival_time;
		logic [BUR_W-1:0] burst_length;
	} job_word_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} rpt_ctl_t;

endpackage

>>> src/ljf_ram.sv
// ----------------------------------------------------------------------------
// ljf_ram
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module ljf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/ljf_sched.sv
// ----------------------------------------------------------------------------
// ljf_sched
// Load sequencer and scheduling engine: scans the job memory once per
// decision, picks the longest arrived job and records its completion.
// ----------------------------------------------------------------------------
module ljf_sched #(
	parameter int MAX_JOBS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        job_last,
	output logic                        busy,
	output logic                        jw_en,
	output logic [$clog2(MAX_JOBS)-1:0] jw_addr,
	output logic [$clog2(MAX_JOBS)-1:0] raddr,
	input  ljf_pkg::job_word_t          jrd,
	output logic                        cw_en,
	output logic [$clog2(MAX_JOBS)-1:0] cw_addr,
	output logic [ljf_pkg::TIME_W-1:0]  cw_data,
	output ljf_pkg::rpt_ctl_t           rpt
);
	import ljf_pkg::*;

	localparam int IW = $clog2(MAX_JOBS);
	localparam int CW = $clog2(MAX_JOBS + 1);

	typedef enum logic [3:0] {
		S_LOAD   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DECIDE = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       done_q;
	logic [CW-1:0]       cnt_q;
	logic [TIME_W-1:0]   time_q;
	logic [MAX_JOBS-1:0] fin_q;
	logic                have_pick_q;
	logic [IW-1:0]       pick_q;
	logic [BUR_W-1:0]    best_q;
	logic                have_e_q;
	logic [TIME_W-1:0]   earliest_q;
	logic                scan_v_s1;
	logic [IW-1:0]       scan_idx_s1;
	rpt_ctl_t            rpt_s1;

	logic                accept;
	logic                unfinished;
	logic                arrived;
	logic [TIME_W-1:0]   ct_next;
	logic                take_pick;
	logic                take_early;

	assign busy    = (state_q != S_LOAD);
	assign accept  = start && !busy;
	assign jw_en   = accept && (count_q < CW'(MAX_JOBS));
	assign jw_addr = count_q[IW-1:0];
	assign raddr   = cnt_q[IW-1:0];
	assign ct_next = time_q + TIME_W'(best_q);
	assign cw_en   = (state_q == S_DECIDE) && have_pick_q;
	assign cw_addr = pick_q;
	assign cw_data = ct_next;
	assign rpt     = rpt_s1;

	always_comb begin
		unfinished = !fin_q[scan_idx_s1];
		arrived    = (TIME_W'(jrd.arrival_time) <= time_q);
		take_pick  = scan_v_s1 && unfinished && arrived
			&& (!have_pick_q || (jrd.burst_length > best_q));
		take_early = scan_v_s1 && unfinished
			&& (!have_e_q || (TIME_W'(jrd.arrival_time) < earliest_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			count_q     <= '0;
			done_q      <= '0;
			cnt_q       <= '0;
			time_q      <= '0;
			fin_q       <= '0;
			have_pick_q <= 1'b0;
			pick_q      <= '0;
			best_q      <= '0;
			have_e_q    <= 1'b0;
			earliest_q  <= '0;
			scan_v_s1   <= 1'b0;
			scan_idx_s1 <= '0;
			rpt_s1      <= '0;
		end else begin
			scan_v_s1    <= 1'b0;
			rpt_s1.valid <= 1'b0;
			if (take_pick) begin
				have_pick_q <= 1'b1;
				pick_q      <= scan_idx_s1;
				best_q      <= jrd.burst_length;
			end
			if (take_early) begin
				have_e_q   <= 1'b1;
				earliest_q <= TIME_W'(jrd.arrival_time);
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (jw_en) begin
							count_q <= count_q + CW'(1);
						end
						if (job_last) begin
							state_q     <= S_SCAN;
							cnt_q       <= '0;
							have_pick_q <= 1'b0;
							have_e_q    <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q < count_q) begin
						scan_v_s1   <= 1'b1;
						scan_idx_s1 <= cnt_q[IW-1:0];
						cnt_q       <= cnt_q + CW'(1);
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q       <= '0;
					have_pick_q <= 1'b0;
					have_e_q    <= 1'b0;
					if (have_pick_q) begin
						time_q         <= ct_next;
						fin_q[pick_q]  <= 1'b1;
						done_q         <= done_q + CW'(1);
						if ((done_q + CW'(1)) == count_q) begin
							state_q <= S_REPORT;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						time_q  <= earliest_q;
						state_q <= S_SCAN;
					end
				end
				S_REPORT: begin
					rpt_s1.valid <= 1'b1;
					rpt_s1.last  <= (cnt_q == (count_q - CW'(1)));
					rpt_s1.idx   <= IDX_W'(cnt_q);
					cnt_q        <= cnt_q + CW'(1);
					if (cnt_q == (count_q - CW'(1))) begin
						state_q <= S_LOAD;
						count_q <= '0;
						done_q  <= '0;
						time_q  <= '0;
						fin_q   <= '0;
						cnt_q   <= '0;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_pick_unfinished: assert property (@(posedge clk) disable iff (!arst_n)
		cw_en |-> !fin_q[pick_q])
		else $error("picked job already finished");

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q <= count_q)
		else $error("more jobs finished than loaded");

	a_fin_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fin_q) == int'(done_q))
		else $error("finished marks disagree with finished count");

	a_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOAD |-> fin_q == '0)
		else $error("finished marks not cleared while loading");

	a_jump_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && !have_pick_q) |-> have_e_q)
		else $error("time jump without a pending job");
`endif

endmodule

>>> src/ljf_report.sv
// ----------------------------------------------------------------------------
// ljf_report
// Result stage: derives turnaround and waiting time from stored entries
// and registers one result per cycle with its strobe.
// ----------------------------------------------------------------------------
module ljf_report (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ljf_pkg::rpt_ctl_t          rpt,
	input  ljf_pkg::job_word_t         jrd,
	input  logic [ljf_pkg::TIME_W-1:0] ct,
	output logic                       strobe,
	output ljf_pkg::result_t           result
);
	import ljf_pkg::*;

	logic              strobe_q;
	result_t           result_q;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] wt;

	always_comb begin
		tat = ct - TIME_W'(jrd.arrival_time);
		wt  = tat - TIME_W'(jrd.burst_length);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= rpt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rpt.valid) begin
			result_q.job_index       <= rpt.idx;
			result_q.completion_time <= ct;
			result_q.turnaround_time <= tat;
			result_q.waiting_time    <= wt;
			result_q.last_result     <= rpt.last;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

>>> src/longest_job_first_scheduler_top.sv
// ----------------------------------------------------------------------------
// longest_job_first_scheduler_top
// Non-preemptive longest-job-first scheduler over a job memory and a
// completion memory.
//
//   channel | ports                | handshake
//   --------+----------------------+---------------------------------
//   job in  | start, busy, job     | taken when start && !busy
//   result  | strobe, result       | one result per strobe, no stall
//
// Loading takes one transaction per cycle while busy is low.
// A transaction with last_job raises busy; each decision scans all N loaded
// jobs through the job memory's single read port; at most 2N decisions run.
// Reporting reads one entry per cycle; each result passes the registered
// memory read and then the result register.
// Reset clears all control state; no memory clearing pass is needed.
// The receiver cannot stall: each strobe must be taken.
// ----------------------------------------------------------------------------
module longest_job_first_scheduler_top #(
	parameter int MAX_JOBS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ljf_pkg::job_t    job,
	output logic             busy,
	output logic             strobe,
	output ljf_pkg::result_t result
);
	import ljf_pkg::*;

	localparam int IW = $clog2(MAX_JOBS);

	logic              jw_en;
	logic [IW-1:0]     jw_addr;
	logic [IW-1:0]     raddr;
	job_word_t         jw_data;
	job_word_t         jrd;
	logic              cw_en;
	logic [IW-1:0]     cw_addr;
	logic [TIME_W-1:0] cw_data;
	logic [TIME_W-1:0] crd;
	rpt_ctl_t          rpt;

	assign jw_data.arrival_time = job.arrival_time;
	assign jw_data.burst_length = job.burst_length;

	ljf_ram #(
		.WIDTH ($bits(job_word_t)),
		.DEPTH (MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (jw_en),
		.waddr (jw_addr),
		.wdata (jw_data),
		.raddr (raddr),
		.rdata (jrd)
	);

	ljf_ram #(
		.WIDTH (TIME_W),
		.DEPTH (MAX_JOBS)
	) u_cmp_ram (
		.clk   (clk),
		.we    (cw_en),
		.waddr (cw_addr),
		.wdata (cw_data),
		.raddr (raddr),
		.rdata (crd)
	);

	ljf_sched #(
		.MAX_JOBS (MAX_JOBS)
	) u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.job_last (job.last_job),
		.busy     (busy),
		.jw_en    (jw_en),
		.jw_addr  (jw_addr),
		.raddr    (raddr),
		.jrd      (jrd),
		.cw_en    (cw_en),
		.cw_addr  (cw_addr),
		.cw_data  (cw_data),
		.rpt      (rpt)
	);

	ljf_report u_report (
		.clk    (clk),
		.arst_n (arst_n),
		.rpt    (rpt),
		.jrd    (jrd),
		.ct     (crd),
		.strobe (strobe),
		.result (result)
	);

endmodule

>>> dv/ljf_schedule_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ljf_schedule_checker
// Watches the job and result channels of the longest-job-first scheduler,
// computes the expected schedule of each job set on its own and compares
// every result with the oldest expected one.
// ----------------------------------------------------------------------------
module ljf_schedule_checker #(
	parameter int MAX_JOBS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  ljf_pkg::job_t    job,
	input  logic             strobe,
	input  ljf_pkg::result_t result,
	output int               mismatches,
	output int               outstanding
);
	import ljf_pkg::*;

	logic [ARR_W-1:0] arrival_mem [MAX_JOBS];
	logic [BUR_W-1:0] burst_mem [MAX_JOBS];
	int               held_jobs;
	result_t          expected_reports [$];

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
		end
	endtask

	function automatic void predict_schedule();
		bit                finished [MAX_JOBS];
		logic [TIME_W-1:0] finish_at [MAX_JOBS];
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] earliest;
		logic [TIME_W-1:0] turnaround;
		int                pick;
		int                remaining;
		result_t           r;
		now = '0;
		remaining = held_jobs;
		foreach (finished[k]) finished[k] = 1'b0;
		while (remaining > 0) begin
			pick = -1;
			earliest = '1;
			for (int k = 0; k < held_jobs; k++) begin
				if (!finished[k]) begin
					if (TIME_W'(arrival_mem[k]) <= now &&
							(pick < 0 || burst_mem[k] > burst_mem[pick])) begin
						pick = k;
					end
					if (TIME_W'(arrival_mem[k]) < earliest) earliest = TIME_W'(arrival_mem[k]);
				end
			end
			if (pick < 0) begin
				now = earliest;
			end else begin
				now = now + TIME_W'(burst_mem[pick]);
				finish_at[pick] = now;
				finished[pick] = 1'b1;
				remaining--;
			end
		end
		for (int k = 0; k < held_jobs; k++) begin
			turnaround = finish_at[k] - TIME_W'(arrival_mem[k]);
			r.job_index = IDX_W'(k);
			r.completion_time = finish_at[k];
			r.turnaround_time = turnaround;
			r.waiting_time = turnaround - TIME_W'(burst_mem[k]);
			r.last_result = (k == held_jobs - 1);
			expected_reports.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held_jobs = 0;
			expected_reports.delete();
		end else begin
			if (strobe) begin
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("result for job %0d with none expected",
						result.job_index));
				end else begin
					want = expected_reports.pop_front();
					check_field("job_index", TIME_W'(result.job_index), TIME_W'(want.job_index));
					check_field("completion_time", result.completion_time,
						want.completion_time);
					check_field("turnaround_time", result.turnaround_time,
						want.turnaround_time);
					check_field("waiting_time", result.waiting_time, want.waiting_time);
					check_field("last_result", TIME_W'(result.last_result),
						TIME_W'(want.last_result));
				end
			end
			if (start && !busy) begin
				if (held_jobs < MAX_JOBS) begin
					arrival_mem[held_jobs] = job.arrival_time;
					burst_mem[held_jobs] = job.burst_length;
					held_jobs++;
				end
				if (job.last_job) begin
					predict_schedule();
					held_jobs = 0;
				end
			end
		end
		outstanding <= expected_reports.size();
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives job sets into the longest-job-first scheduler: a directed part
// with field extremes, ties, idle time jumps and an overfilled store, then
// random sets with random gaps on the job channel. The checker beside the
// block does the comparing; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import ljf_pkg::*;

	localparam int MAX_JOBS     = 16;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 150;
	localparam int QUIET_TAIL   = 30;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	job_t    job;
	logic    busy;
	logic    strobe;
	result_t result;
	int      mismatches;
	int      outstanding;
	int      stall_cycles;
	int      gap_chance;
	int      items_sent;

	longest_job_first_scheduler_top #(
		.MAX_JOBS(MAX_JOBS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.job    (job),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	ljf_schedule_checker #(
		.MAX_JOBS(MAX_JOBS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.job         (job),
		.strobe      (strobe),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (stall_cycles < STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic push_job(input logic [ARR_W-1:0] arrival, input logic [BUR_W-1:0] burst,
			input logic final_job);
		job_t j;
		if (gap_chance != 0 && $urandom_range(0, 3) < gap_chance) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		j.arrival_time = arrival;
		j.burst_length = burst;
		j.last_job = final_job;
		start <= 1'b1;
		job <= j;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic send_random_set();
		int set_size;
		int arrival_max;
		int burst_max;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 3);
		else if (pick < 4) set_size = $urandom_range(1, 3);
		else set_size = $urandom_range(4, MAX_JOBS);
		case ($urandom_range(0, 2))
			0: arrival_max = 0;
			1: arrival_max = 255;
			default: arrival_max = 65535;
		endcase
		case ($urandom_range(0, 2))
			0: burst_max = 7;
			1: burst_max = 1023;
			default: burst_max = 65535;
		endcase
		for (int i = 0; i < set_size; i++) begin
			push_job(ARR_W'($urandom_range(0, arrival_max)), BUR_W'($urandom_range(0, burst_max)),
				i == set_size - 1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		job = '0;
		gap_chance = 0;
		items_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single job sets at the field extremes
		push_job('0, '0, 1'b1);
		push_job('1, '1, 1'b1);
		// equal bursts, then an idle jump to a late arrival
		push_job(16'd10, 16'd4, 1'b0);
		push_job(16'd10, 16'd4, 1'b0);
		push_job(16'd20, 16'd1, 1'b1);
		// full store, then one dropped job and a dropped last job
		for (int i = 0; i < MAX_JOBS; i++) begin
			push_job(ARR_W'(i * 4096), BUR_W'(16'hFFFF - i * 4369), 1'b0);
		end
		push_job(16'h5555, 16'hAAAA, 1'b0);
		push_job(16'hAAAA, 16'h5555, 1'b1);

		while (items_sent < RANDOM_ITEMS) begin
			gap_chance = (items_sent > RANDOM_ITEMS - QUIET_TAIL) ? 0 : $urandom_range(0, 2);
			send_random_set();
		end
		start <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
